// ===== design/sgdma_pkg.sv =====
// Shared types, constants and codes for the scatter-gather transfer sequencer.
package sgdma_pkg;

    localparam int TableDepth = 16;
    localparam int IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
    localparam int CntW       = $clog2(TableDepth + 1);

    // Command codes
    localparam logic [1:0] CMD_LOAD_SRC = 2'd0;
    localparam logic [1:0] CMD_LOAD_DST = 2'd1;
    localparam logic [1:0] CMD_RESTART  = 2'd2;
    localparam logic [1:0] CMD_COMPLETE = 2'd3;

    // Register indexes
    localparam logic [2:0] REG_PERIOD_LEN   = 3'd0;
    localparam logic [2:0] REG_HOST_BUF_LEN = 3'd1;
    localparam logic [2:0] REG_REPORT_LEN   = 3'd2;
    localparam logic [2:0] REG_SRC_ENTRIES  = 3'd3;
    localparam logic [2:0] REG_DST_ENTRIES  = 3'd4;

    // Controller to datapath commands
    typedef struct packed {
        logic       load_src;
        logic       load_dst;
        logic       restart;
        logic       cmp_a;     // completion: position and address advance
        logic       cmp_b;     // completion: element step
        logic       cmp_c;     // completion: clamp and split
        logic       capture;   // latch result word
    } t_dp_cmd;

    // Result word
    typedef struct packed {
        logic [31:0] stream_pos;
        logic [23:0] host_read_pos;
        logic        report_fire;
        logic        period_done;
        logic        chain_now;
        logic [23:0] next_len;
        logic [31:0] next_dst;
        logic [31:0] next_src;
    } t_result;

    // Saturating entry count to an effective count
    function automatic logic [CntW-1:0] eff_count(input logic [4:0] n);
        logic [CntW-1:0] r;
        begin
            if (n == 5'd0) begin
                r = CntW'(1);
            end else if (32'(n) > TableDepth) begin
                r = CntW'(TableDepth);
            end else begin
                r = CntW'(n);
            end
            return r;
        end
    endfunction

endpackage

// ===== design/sg_dma_split_transfer_sequencer.sv =====
// Top level of the scatter-gather transfer sequencer.
// One command word in gives one result word out. Loads and restarts update
// the datapath directly, and a completion runs three datapath phases
// (position and address advance, element step, clamp and split); each word
// then captures the result register. The next word is accepted once the
// previous result is captured and the result slot is free or draining.
// Result tdata holds next_src, next_dst, next_len, chain_now,
// period_done, report_fire, host_read_pos, stream_pos from the low bit up.
module sg_dma_split_transfer_sequencer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // entry_index, entry_addr, entry_len
    input  logic [1:0]   s_axis_tuser,   // cmd
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [151:0] m_axis_tdata,   // next_src..stream_pos (147 bits used)
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [23:0]  cfg_data
);
    import sgdma_pkg::*;

    logic [23:0] r_period_len, r_host_buffer_len, r_report_period_len;
    logic [4:0]  r_source_entries, r_sink_entries;
    t_dp_cmd     dp_cmd;
    t_result     res;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_len        <= 24'd1;
            r_host_buffer_len   <= 24'd1;
            r_report_period_len <= 24'd0;
            r_source_entries    <= 5'd1;
            r_sink_entries      <= 5'd1;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_PERIOD_LEN:   r_period_len        <= cfg_data;
                REG_HOST_BUF_LEN: r_host_buffer_len   <= cfg_data;
                REG_REPORT_LEN:   r_report_period_len <= cfg_data;
                REG_SRC_ENTRIES:  r_source_entries    <= cfg_data[4:0];
                REG_DST_ENTRIES:  r_sink_entries      <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    sgdma_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_cmd         (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .o_cmd         (dp_cmd)
    );

    sgdma_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (dp_cmd),
        .i_entry_index       (s_axis_tdata[3:0]),
        .i_entry_addr        (s_axis_tdata[35:4]),
        .i_entry_len         (s_axis_tdata[59:36]),
        .i_period_len        (r_period_len),
        .i_host_buffer_len   (r_host_buffer_len),
        .i_report_period_len (r_report_period_len),
        .i_source_entries    (r_source_entries),
        .i_sink_entries      (r_sink_entries),
        .o_result            (res)
    );

    assign m_axis_tdata = {5'd0, res.stream_pos, res.host_read_pos, res.report_fire,
                           res.period_done, res.chain_now, res.next_len,
                           res.next_dst, res.next_src};

endmodule

// ===== design/sgdma_ctrl.sv =====
// Sequencer controller: handshakes and completion phase sequencing.
module sgdma_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [1:0]          i_cmd,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output sgdma_pkg::t_dp_cmd  o_cmd
);
    import sgdma_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CB   = 3'd2;
    localparam logic [2:0] ST_CC   = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;
    logic       acc;

    // Accept when idle and the output slot is free or being drained
    assign s_axis_tready = (r_state == ST_IDLE) && (!r_ovalid || m_axis_tready);
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid;
        o_cmd    = '0;
        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    case (i_cmd)
                        CMD_LOAD_SRC: o_cmd.load_src = 1'b1;
                        CMD_LOAD_DST: o_cmd.load_dst = 1'b1;
                        CMD_RESTART:  o_cmd.restart  = 1'b1;
                        default:      o_cmd.cmp_a    = 1'b1;
                    endcase
                    n_state = (i_cmd == CMD_COMPLETE) ? ST_CB : ST_OUT;
                end
            end
            ST_CB: begin
                o_cmd.cmp_b = 1'b1;
                n_state     = ST_CC;
            end
            ST_CC: begin
                o_cmd.cmp_c = 1'b1;
                n_state     = ST_OUT;
            end
            ST_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    o_cmd.capture = 1'b1;
                    n_ovalid      = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    // Input only taken when idle
    a_acc_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |-> (r_state == ST_IDLE)) else $error("accept outside idle");
    // Completion walks through all phases
    a_cmp_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.cmp_a |=> o_cmd.cmp_b ##1 o_cmd.cmp_c) else $error("phase order");
    // Capture never overwrites an unread result
    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |-> (!r_ovalid || m_axis_tready)) else $error("overwrite");

endmodule

// ===== design/sgdma_dp.sv =====
// Sequencer datapath: tables, positions, address advance and clamping.
module sgdma_dp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sgdma_pkg::t_dp_cmd     i_cmd,
    input  logic [3:0]             i_entry_index,
    input  logic [31:0]            i_entry_addr,
    input  logic [23:0]            i_entry_len,
    input  logic [23:0]            i_period_len,
    input  logic [23:0]            i_host_buffer_len,
    input  logic [23:0]            i_report_period_len,
    input  logic [4:0]             i_source_entries,
    input  logic [4:0]             i_sink_entries,
    output sgdma_pkg::t_result     o_result
);
    import sgdma_pkg::*;

    logic [31:0] r_src_addr_tab [TableDepth];
    logic [23:0] r_src_len_tab  [TableDepth];
    logic [31:0] r_dst_addr_tab [TableDepth];
    logic [23:0] r_dst_len_tab  [TableDepth];

    logic [IdxW-1:0] r_src_slot, r_dst_slot;
    logic [31:0] r_src_limit, r_dst_limit, r_cur_src, r_cur_dst, r_total_pos;
    logic [23:0] r_cur_len, r_split_left, r_ring_pos, r_report_acc;
    logic        r_fire;
    t_result     r_result;

    logic            idx_ok;
    logic [24:0]     ring_sum, acc_sum;
    logic [IdxW-1:0] src_step, dst_step;
    logic [CntW:0]   src_inc, dst_inc;
    logic [31:0]     src_end, dst_end;
    logic [23:0]     nxt_a, nxt_b, nxt_c, pl;
    logic [31:0]     cand_s, cand_d;

    assign idx_ok = (32'(i_entry_index) < TableDepth);
    assign pl     = i_period_len;

    // Table writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_src && idx_ok) begin
            r_src_addr_tab[IdxW'(i_entry_index)] <= i_entry_addr;
            r_src_len_tab[IdxW'(i_entry_index)]  <= i_entry_len;
        end
        if (i_cmd.load_dst && idx_ok) begin
            r_dst_addr_tab[IdxW'(i_entry_index)] <= i_entry_addr;
            r_dst_len_tab[IdxW'(i_entry_index)]  <= i_entry_len;
        end
    end

    // Phase A arithmetic
    assign ring_sum = {1'b0, r_ring_pos} + {1'b0, r_cur_len};
    assign acc_sum  = {1'b0, r_report_acc} + {1'b0, r_cur_len};

    // Phase B: slot stepping with wrap
    assign src_inc  = {1'b0, CntW'(r_src_slot)} + 1'b1;
    assign dst_inc  = {1'b0, CntW'(r_dst_slot)} + 1'b1;
    assign src_step = (src_inc >= {1'b0, eff_count(i_source_entries)}) ? '0
                                                                     : IdxW'(src_inc);
    assign dst_step = (dst_inc >= {1'b0, eff_count(i_sink_entries)}) ? '0
                                                                   : IdxW'(dst_inc);
    assign src_end  = r_src_addr_tab[src_step] + 32'(r_src_len_tab[src_step]);
    assign dst_end  = r_dst_addr_tab[dst_step] + 32'(r_dst_len_tab[dst_step]);

    // Phase C: clamp to element ends, then split handling
    assign cand_s = r_src_limit - r_cur_src;
    assign cand_d = r_dst_limit - r_cur_dst;
    always_comb begin
        nxt_a = pl;
        if ((r_cur_src + 32'(pl)) > r_src_limit && cand_s < 32'(pl)) begin
            nxt_a = cand_s[23:0];
        end
        nxt_b = nxt_a;
        if ((r_cur_dst + 32'(nxt_a)) > r_dst_limit && cand_d < 32'(nxt_a)) begin
            nxt_b = cand_d[23:0];
        end
        nxt_c = nxt_b;
        if (r_split_left != 24'd0 && r_split_left < nxt_b) begin
            nxt_c = r_split_left;
        end
    end

    // State update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_slot <= '0;          r_dst_slot <= '0;
            r_src_limit <= '0;         r_dst_limit <= '0;
            r_cur_src <= '0;           r_cur_dst <= '0;
            r_cur_len <= '0;           r_split_left <= '0;
            r_ring_pos <= '0;          r_report_acc <= '0;
            r_total_pos <= '0;         r_fire <= 1'b0;
        end else if (i_cmd.restart) begin
            r_src_slot   <= '0;
            r_dst_slot   <= '0;
            r_src_limit  <= r_src_addr_tab[0] + 32'(r_src_len_tab[0]);
            r_dst_limit  <= r_dst_addr_tab[0] + 32'(r_dst_len_tab[0]);
            r_cur_src    <= r_src_addr_tab[0];
            r_cur_dst    <= r_dst_addr_tab[0];
            r_cur_len    <= pl;
            r_split_left <= '0;
            r_ring_pos   <= '0;
            r_report_acc <= '0;
            r_total_pos  <= '0;
            r_fire       <= 1'b0;
        end else if (i_cmd.load_src || i_cmd.load_dst) begin
            r_fire <= 1'b0;
        end else if (i_cmd.cmp_a) begin
            r_ring_pos  <= (ring_sum >= {1'b0, i_host_buffer_len}) ? '0 : ring_sum[23:0];
            r_total_pos <= r_total_pos + 32'(r_cur_len);
            if (i_report_period_len != 24'd0 && acc_sum >= {1'b0, i_report_period_len}) begin
                r_report_acc <= '0;
                r_fire       <= 1'b1;
            end else begin
                r_report_acc <= acc_sum[24] ? 24'hFFFFFF : acc_sum[23:0];
                r_fire       <= 1'b0;
            end
            r_cur_src <= r_cur_src + 32'(r_cur_len);
            r_cur_dst <= r_cur_dst + 32'(r_cur_len);
        end else if (i_cmd.cmp_b) begin
            if (r_cur_src == r_src_limit) begin
                r_src_slot  <= src_step;
                r_src_limit <= src_end;
                r_cur_src   <= r_src_addr_tab[src_step];
            end
            if (r_cur_dst == r_dst_limit) begin
                r_dst_slot  <= dst_step;
                r_dst_limit <= dst_end;
                r_cur_dst   <= r_dst_addr_tab[dst_step];
            end
        end else if (i_cmd.cmp_c) begin
            r_cur_len <= nxt_c;
            if (r_split_left == 24'd0) begin
                if (nxt_b != pl) begin
                    r_split_left <= pl - nxt_b;
                end
            end else begin
                r_split_left <= r_split_left - nxt_c;
            end
        end
    end

    // Chain flag follows the split state seen at phase C
    logic r_chain;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= 1'b0;
        end else if (i_cmd.cmp_c) begin
            r_chain <= (r_split_left != 24'd0);
        end else if (i_cmd.restart || i_cmd.load_src || i_cmd.load_dst) begin
            r_chain <= 1'b0;
        end
    end

    // Result capture; flags only for completions
    logic r_was_cmp;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_was_cmp <= 1'b0;
        end else if (i_cmd.cmp_a) begin
            r_was_cmp <= 1'b1;
        end else if (i_cmd.restart || i_cmd.load_src || i_cmd.load_dst) begin
            r_was_cmp <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_result.next_src      <= r_cur_src;
            r_result.next_dst      <= r_cur_dst;
            r_result.next_len      <= r_cur_len;
            r_result.chain_now     <= r_was_cmp && r_chain;
            r_result.period_done   <= r_was_cmp && !r_chain;
            r_result.report_fire   <= r_was_cmp && r_fire;
            r_result.host_read_pos <= r_ring_pos;
            r_result.stream_pos    <= r_total_pos;
        end
    end

    assign o_result = r_result;

endmodule

// ===== sim/sg_dma_split_transfer_sequencer_checker.sv =====
// Checker for the transfer sequencer: shadows its state, predicts each result word, compares.
`timescale 1ns / 1ps

module sg_dma_split_transfer_sequencer_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_valid,
    input  logic         i_s_ready,
    input  logic [63:0]  i_s_data,
    input  logic [1:0]   i_s_user,
    input  logic         i_m_valid,
    input  logic         i_m_ready,
    input  logic [151:0] i_m_data,
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [23:0]  i_cfg_data,
    output int           o_pending,
    output int           o_errors
);
    import sgdma_pkg::*;

    // shadow tables and sequencer state
    logic [31:0] src_base [TableDepth];
    logic [23:0] src_size [TableDepth];
    logic [31:0] dst_base [TableDepth];
    logic [23:0] dst_size [TableDepth];
    logic [3:0]  src_at, dst_at;
    logic [31:0] src_end, dst_end, cur_src, cur_dst, total;
    logic [23:0] cur_len, split_rem, ring;
    logic [24:0] rep_acc;

    // shadow registers
    logic [23:0] period, ring_size, rep_period;
    logic [4:0]  src_count, dst_count;

    t_result expected_words [$];
    int errors = 0;

    assign o_pending = expected_words.size();
    assign o_errors  = errors;

    function automatic logic [3:0] next_slot(input logic [3:0] slot, input logic [4:0] n);
        int cnt;
        cnt = (n == 0) ? 1 : ((n > TableDepth) ? TableDepth : n);
        return (slot + 1 >= cnt) ? 4'd0 : slot + 4'd1;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : predict
        t_result     r, got, want;
        logic [31:0] nxt, cand, ln, addr;
        logic [24:0] sum;
        logic [3:0]  idx;
        logic [23:0] elen;
        if (!i_rst_n) begin
            src_at = '0; dst_at = '0; src_end = '0; dst_end = '0;
            cur_src = '0; cur_dst = '0; cur_len = '0; split_rem = '0;
            ring = '0; rep_acc = '0; total = '0;
            period = 24'd1; ring_size = 24'd1; rep_period = '0;
            src_count = 5'd1; dst_count = 5'd1;
            expected_words.delete();
        end else begin
            // register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_PERIOD_LEN:   period     = i_cfg_data;
                    REG_HOST_BUF_LEN: ring_size  = i_cfg_data;
                    REG_REPORT_LEN:   rep_period = i_cfg_data;
                    REG_SRC_ENTRIES:  src_count  = i_cfg_data[4:0];
                    REG_DST_ENTRIES:  dst_count  = i_cfg_data[4:0];
                    default: ;
                endcase
            end
            // command word in: predict its result
            if (i_s_valid && i_s_ready) begin
                idx  = i_s_data[3:0];
                addr = i_s_data[35:4];
                elen = i_s_data[59:36];
                r = '0;
                case (i_s_user)
                    CMD_LOAD_SRC: begin
                        src_base[idx] = addr;
                        src_size[idx] = elen;
                    end
                    CMD_LOAD_DST: begin
                        dst_base[idx] = addr;
                        dst_size[idx] = elen;
                    end
                    CMD_RESTART: begin
                        src_at = '0; dst_at = '0;
                        src_end = src_base[0] + src_size[0];
                        dst_end = dst_base[0] + dst_size[0];
                        cur_src = src_base[0];
                        cur_dst = dst_base[0];
                        cur_len = period;
                        split_rem = '0; ring = '0; rep_acc = '0; total = '0;
                    end
                    default: begin
                        ln = {8'd0, cur_len};
                        sum = {1'b0, ring} + {1'b0, cur_len};
                        ring = (sum >= {1'b0, ring_size}) ? 24'd0 : sum[23:0];
                        total = total + ln;
                        rep_acc = rep_acc + {1'b0, cur_len};
                        if (rep_period != 0 && rep_acc >= {1'b0, rep_period}) begin
                            rep_acc = '0;
                            r.report_fire = 1'b1;
                        end else if (rep_acc > 25'hFFFFFF) begin
                            rep_acc = 25'hFFFFFF;
                        end
                        cur_src = cur_src + ln;
                        cur_dst = cur_dst + ln;
                        // step to next element on reaching an element end
                        if (cur_src == src_end) begin
                            src_at = next_slot(src_at, src_count);
                            src_end = src_base[src_at] + src_size[src_at];
                            cur_src = src_base[src_at];
                        end
                        if (cur_dst == dst_end) begin
                            dst_at = next_slot(dst_at, dst_count);
                            dst_end = dst_base[dst_at] + dst_size[dst_at];
                            cur_dst = dst_base[dst_at];
                        end
                        // clamp to both element ends, wrapped difference
                        nxt = {8'd0, period};
                        if (cur_src + nxt > src_end) begin
                            cand = src_end - cur_src;
                            if (cand < nxt) nxt = cand;
                        end
                        if (cur_dst + nxt > dst_end) begin
                            cand = dst_end - cur_dst;
                            if (cand < nxt) nxt = cand;
                        end
                        // split periods chain at once
                        if (split_rem == 0) begin
                            if (nxt != {8'd0, period}) split_rem = period - nxt[23:0];
                            r.period_done = 1'b1;
                        end else begin
                            r.chain_now = 1'b1;
                            if ({8'd0, split_rem} < nxt) nxt = {8'd0, split_rem};
                            split_rem = split_rem - nxt[23:0];
                        end
                        cur_len = nxt[23:0];
                    end
                endcase
                r.next_src = cur_src;
                r.next_dst = cur_dst;
                r.next_len = cur_len;
                r.host_read_pos = ring;
                r.stream_pos = total;
                expected_words.push_back(r);
            end
            // result word out: compare with oldest
            if (i_m_valid && i_m_ready) begin
                got = t_result'(i_m_data[$bits(t_result)-1:0]);
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected result word, expected none actual %h", $time, got);
                    errors++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("next_src", want.next_src, got.next_src);
                    check_field("next_dst", want.next_dst, got.next_dst);
                    check_field("next_len", want.next_len, got.next_len);
                    check_field("chain_now", want.chain_now, got.chain_now);
                    check_field("period_done", want.period_done, got.period_done);
                    check_field("report_fire", want.report_fire, got.report_fire);
                    check_field("host_read_pos", want.host_read_pos, got.host_read_pos);
                    check_field("stream_pos", want.stream_pos, got.stream_pos);
                end
            end
        end
    end

endmodule

// ===== sim/sg_dma_split_transfer_sequencer_test.sv =====
// Testbench top: clock, reset, command and register stimulus, and the verdict.
`timescale 1ns / 1ps

module sg_dma_split_transfer_sequencer_test;
    import sgdma_pkg::*;

    localparam int CycleLimit = 300000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = CMD_LOAD_SRC;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [151:0] m_axis_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = REG_PERIOD_LEN;
    logic [23:0]  cfg_data = '0;

    int pending, errors;
    int cycles = 0;
    bit calm = 1'b0;       // no idling on either side
    bit hold_req = 1'b0;   // receiver stalls for a long stretch
    logic [23:0] cur_period = 24'd1;

    always #10 i_clk = ~i_clk;

    sg_dma_split_transfer_sequencer dut (.*);

    sg_dma_split_transfer_sequencer_checker checker_i (
        .i_clk, .i_rst_n,
        .i_s_valid(s_axis_tvalid), .i_s_ready(s_axis_tready),
        .i_s_data(s_axis_tdata), .i_s_user(s_axis_tuser),
        .i_m_valid(m_axis_tvalid), .i_m_ready(m_axis_tready), .i_m_data(m_axis_tdata),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_pending(pending), .o_errors(errors)
    );

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("sg_dma_split_transfer_sequencer verification failed");
            $finish;
        end
    end

    // result receiver with random stalls
    initial begin : receiver
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = calm ? 0 : $urandom_range(0, 4);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(negedge i_clk);
            while (!m_axis_tvalid) @(negedge i_clk);
            @(posedge i_clk);
        end
    end

    task automatic send_word(input logic [1:0] cmd, input logic [3:0] idx,
                             input logic [31:0] addr, input logic [23:0] elen);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {4'd0, elen, addr, idx};
        @(negedge i_clk);
        while (!s_axis_tready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge i_clk);
        while (!cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        cfg_valid <= 1'b0;
        if (idx == REG_PERIOD_LEN) cur_period = value;
    endtask

    // drain all results, then let the block settle before register writes
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic configure(input logic [23:0] per, input logic [23:0] ring,
                             input logic [23:0] rep, input logic [4:0] ns, input logic [4:0] nd);
        write_reg(REG_PERIOD_LEN, per);
        write_reg(REG_HOST_BUF_LEN, ring);
        write_reg(REG_REPORT_LEN, rep);
        write_reg(REG_SRC_ENTRIES, {19'd0, ns});
        write_reg(REG_DST_ENTRIES, {19'd0, nd});
    endtask

    // element length mostly whole periods, sometimes ragged; fully random for periods above 4096
    function automatic logic [23:0] element_len();
        logic [31:0] l;
        if (cur_period > 24'd4096) return 24'($urandom);
        l = cur_period * $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) l = l + $urandom_range(0, cur_period);
        return l[23:0];
    endfunction

    task automatic load_entry(input bit sink, input logic [3:0] idx);
        send_word(sink ? CMD_LOAD_DST : CMD_LOAD_SRC, idx, $urandom, element_len());
    endtask

    initial begin : stimulus
        int mode, n;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: fill both tables, then walk elements with splits
        configure(24'd8, 24'd40, 24'd16, 5'd3, 5'd2);
        for (int i = 0; i < TableDepth; i++) begin
            send_word(CMD_LOAD_SRC, 4'(i), 32'h1000 + 32'(i) * 32'h100, 24'd12 + 24'(i));
            send_word(CMD_LOAD_DST, 4'(i), 32'h8000 + 32'(i) * 32'h100, 24'd20);
        end
        send_word(CMD_RESTART, 4'd0, '0, '0);
        repeat (10) send_word(CMD_COMPLETE, 4'd0, '0, '0);
        // address wrap past 2^32 and an element ending behind its address
        send_word(CMD_LOAD_SRC, 4'd0, 32'hFFFF_FFFC, 24'd16);
        send_word(CMD_LOAD_DST, 4'd0, 32'hFFFF_FFFF, 24'd0);
        send_word(CMD_LOAD_SRC, 4'd15, 32'hFFFF_FFFF, 24'hFF_FFFF);
        send_word(CMD_LOAD_DST, 4'd15, 32'h0, 24'h0);
        send_word(CMD_RESTART, 4'd0, '0, '0);
        repeat (6) send_word(CMD_COMPLETE, 4'd0, '0, '0);
        drain();

        // random phases with varied and extreme settings
        for (int ph = 0; ph < 11; ph++) begin
            mode = ph % 4;
            case (ph)
                0: configure(24'd1, 24'd1, 24'd0, 5'd1, 5'd1);
                1: configure(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 5'd16, 5'd16);
                2: configure(24'd16, 24'd100, 24'd0, 5'd0, 5'd31);
                default: configure(24'($urandom_range(1, 64)), 24'($urandom_range(1, 300)),
                                   24'($urandom_range(0, 100)), 5'($urandom_range(0, 31)),
                                   5'($urandom_range(0, 31)));
            endcase
            calm = (mode == 1);
            if (ph == 4) hold_req = 1'b1;
            for (int i = 0; i < 4; i++) load_entry(i[0], 4'($urandom_range(0, 15)));
            send_word(CMD_RESTART, 4'($urandom), $urandom, 24'($urandom));
            for (int k = 0; k < 31; k++) begin
                n = $urandom_range(0, 99);
                if (n < 78) send_word(CMD_COMPLETE, 4'($urandom), $urandom, 24'($urandom));
                else if (n < 90) load_entry(n[0], 4'($urandom_range(0, 15)));
                else if (n < 95) send_word(CMD_RESTART, 4'($urandom), $urandom, 24'($urandom));
                else send_word(2'(n[0]), 4'($urandom), $urandom, 24'($urandom));
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("sg_dma_split_transfer_sequencer verification clean");
        end else begin
            $display("sg_dma_split_transfer_sequencer verification failed");
        end
        $finish;
    end

endmodule
